>>> rtl/srle_pkg.sv
// ----------------------------------------------------------------------------
// srle_pkg
// shared types, codes and defaults for the sgi rle row decoder
// ----------------------------------------------------------------------------
package srle_pkg;

    localparam int unsigned DEF_MAX_ROW_LENGTH = 8192;
    localparam int unsigned DEF_OUT_LANES      = 4;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned RLEN_W  = 14;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned LANE_W  = 3;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned CDATA_W = 14;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_WIDE_WORDS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SWAP_BYTES = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_ROW_LENGTH = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;   // accept the presented word
        logic emit;   // load the next group into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic has_result;   // presented word causes at least one result
        logic final_group;  // pending group is the last of its word
    } t_dp_stat;

endpackage

>>> rtl/srle_ctrl.sv
// ----------------------------------------------------------------------------
// srle_ctrl
// handshake controller: input acceptance, group emission, output valid
// ----------------------------------------------------------------------------
module srle_ctrl
    import srle_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  logic     i_out_stall,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   emit_now;
    logic   in_ready;
    logic   accept;

    always_comb begin
        emit_now    = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
        in_ready    = (r_state == S_IDLE) || (emit_now && i_stat.final_group);
        accept      = i_in_valid && in_ready;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        case (r_state)
            S_IDLE: begin
                if (accept && i_stat.has_result) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (accept) begin
                    n_state = i_stat.has_result ? S_EMIT : S_IDLE;
                end else if (emit_now && i_stat.final_group) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (emit_now) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = accept;
    assign o_cmd.emit  = emit_now;

endmodule

>>> rtl/srle_dpath.sv
// ----------------------------------------------------------------------------
// srle_dpath
// config registers, row parsing state, group emitter and output register
// ----------------------------------------------------------------------------
module srle_dpath
    import srle_pkg::*;
#(
    parameter int unsigned MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
    parameter int unsigned OUT_LANES      = DEF_OUT_LANES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CDATA_W-1:0]  i_cfg_data,
    input  logic [WORD_W-1:0]   i_word,
    input  logic                i_input_end,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic [WORD_W-1:0]   o_value_a,
    output logic [WORD_W-1:0]   o_value_b,
    output logic [WORD_W-1:0]   o_value_c,
    output logic [WORD_W-1:0]   o_value_d,
    output logic [LANE_W-1:0]   o_lanes_valid,
    output logic                o_row_done,
    output logic [1:0]          o_status,
    output logic                o_last
);

    localparam int unsigned RLEN_MAX_I = (1 << RLEN_W) - 1;
    localparam int unsigned CAP_I      = (MAX_ROW_LENGTH < RLEN_MAX_I) ?
                                         MAX_ROW_LENGTH : RLEN_MAX_I;
    localparam logic [RLEN_W-1:0] LEN_CAP = RLEN_W'(CAP_I);
    localparam int unsigned LANES_I    = (OUT_LANES < 1) ? 1 :
                                         ((OUT_LANES > 4) ? 4 : OUT_LANES);
    localparam logic [LANE_W-1:0] LANE_N = LANE_W'(LANES_I);
    localparam int unsigned NLANE_OUT  = 4;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_RUN     = 2'd1,
        PH_LITERAL = 2'd2
    } t_phase;

    // configuration
    logic              r_wide;
    logic              r_swap;
    logic [RLEN_W-1:0] r_row_len;

    // row parsing state
    t_phase            r_phase;
    logic [CNT_W-1:0]  r_lit_left;
    logic [CNT_W-1:0]  r_run_count;
    logic [RLEN_W-1:0] r_pos;

    // pending groups of the accepted word
    logic [WORD_W-1:0] r_val;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_fin_done;
    t_status           r_fin_st;

    // output register
    logic [WORD_W-1:0] r_lane [NLANE_OUT];
    logic [LANE_W-1:0] r_lanes;
    logic              r_done;
    t_status           r_st;
    logic              r_last;

    logic [WORD_W-1:0] w;
    logic [RLEN_W-1:0] eff_len;
    logic [RLEN_W-1:0] room;
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  lit_dec;
    logic [CNT_W-1:0]  take;
    logic [CNT_W-1:0]  hdr_count;
    logic              is_value;
    logic              more;
    logic              comp;
    logic              over;
    logic              hdr_err;
    logic [LANE_W-1:0] grp;
    logic              fin;

    always_comb begin
        if (!r_wide) begin
            w = {8'h00, i_word[7:0]};
        end else if (r_swap) begin
            w = {i_word[7:0], i_word[15:8]};
        end else begin
            w = i_word;
        end

        if (r_row_len == '0) begin
            eff_len = RLEN_W'(1);
        end else if (r_row_len > LEN_CAP) begin
            eff_len = LEN_CAP;
        end else begin
            eff_len = r_row_len;
        end

        room      = (r_pos < eff_len) ? (eff_len - r_pos) : '0;
        is_value  = (r_phase != PH_HEADER);
        lit_dec   = r_lit_left - CNT_W'(1);
        n         = (r_phase == PH_RUN) ? r_run_count : CNT_W'(1);
        more      = (r_phase == PH_LITERAL) && (lit_dec != '0);
        comp      = {{(RLEN_W-CNT_W){1'b0}}, n} >= room;
        take      = comp ? room[CNT_W-1:0] : n;
        over      = ({{(RLEN_W-CNT_W){1'b0}}, n} > room) || more;
        hdr_count = w[CNT_W-1:0];
        hdr_err   = i_input_end && ((hdr_count != '0) || (r_pos != '0));

        // group size and last-group flag of the pending word
        grp = (r_cnt < {{(CNT_W-LANE_W){1'b0}}, LANE_N}) ? r_cnt[LANE_W-1:0] : LANE_N;
        fin = (r_cnt <= {{(CNT_W-LANE_W){1'b0}}, LANE_N});
    end

    assign o_stat.has_result  = is_value || hdr_err;
    assign o_stat.final_group = fin;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide    <= 1'b0;
            r_swap    <= 1'b0;
            r_row_len <= RLEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDE_WORDS: r_wide    <= i_cfg_data[0];
                CFG_SWAP_BYTES: r_swap    <= i_cfg_data[0];
                CFG_ROW_LENGTH: r_row_len <= i_cfg_data[RLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // row state, updated once per accepted word; pending count, lowered per emitted group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_lit_left  <= '0;
            r_run_count <= '0;
            r_pos       <= '0;
            r_cnt       <= '0;
        end else if (i_cmd.load) begin
            if (!is_value) begin
                if (hdr_err) begin
                    r_phase     <= PH_HEADER;
                    r_lit_left  <= '0;
                    r_run_count <= '0;
                    r_pos       <= '0;
                end else if (hdr_count != '0) begin
                    if (w[7]) begin
                        r_phase    <= PH_LITERAL;
                        r_lit_left <= hdr_count;
                    end else begin
                        r_phase     <= PH_RUN;
                        r_run_count <= hdr_count;
                    end
                end
                r_cnt <= '0;
            end else begin
                if (comp || i_input_end) begin
                    r_phase     <= PH_HEADER;
                    r_lit_left  <= '0;
                    r_run_count <= '0;
                    r_pos       <= '0;
                end else begin
                    r_pos <= r_pos + {{(RLEN_W-CNT_W){1'b0}}, take};
                    if (r_phase == PH_RUN) begin
                        r_phase     <= PH_HEADER;
                        r_run_count <= '0;
                    end else begin
                        r_lit_left <= lit_dec;
                        if (lit_dec == '0) begin
                            r_phase <= PH_HEADER;
                        end
                    end
                end
                r_cnt <= take;
            end
        end else if (i_cmd.emit) begin
            r_cnt <= r_cnt - {{(CNT_W-LANE_W){1'b0}}, grp};
        end
    end

    // pending word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (!is_value) begin
                r_val      <= '0;
                r_fin_done <= 1'b0;
                r_fin_st   <= ST_TRUNC;
            end else begin
                r_val      <= w;
                r_fin_done <= comp;
                if (comp) begin
                    r_fin_st <= over ? ST_OVERFLOW : ST_OK;
                end else begin
                    r_fin_st <= i_input_end ? ST_TRUNC : ST_OK;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            for (int j = 0; j < NLANE_OUT; j++) begin
                r_lane[j] <= (LANE_W'(j) < grp) ? r_val : '0;
            end
            r_lanes <= grp;
            r_done  <= fin && r_fin_done;
            r_st    <= fin ? r_fin_st : ST_OK;
            r_last  <= fin;
        end
    end

    assign o_value_a     = r_lane[0];
    assign o_value_b     = r_lane[1];
    assign o_value_c     = r_lane[2];
    assign o_value_d     = r_lane[3];
    assign o_lanes_valid = r_lanes;
    assign o_row_done    = r_done;
    assign o_status      = r_st;
    assign o_last        = r_last;

endmodule

>>> rtl/sgi_rle_row_decoder.sv
// ----------------------------------------------------------------------------
// sgi_rle_row_decoder
// sgi run-length row decoder: coded words in, groups of decoded values out
// ----------------------------------------------------------------------------
// path: a value word is held in the pending-word registers at its transfer,
//   and its groups move from there into the output register when it is free;
//   header words cause no result unless they end the input with an error
// throughput: literal words go at one per cycle while the output is not stalled,
//   set by the group emitter, which loads one group into the output register per cycle
// reset: synchronous, active low; clears config, row state and output valid
// ----------------------------------------------------------------------------
module sgi_rle_row_decoder
    import srle_pkg::*;
#(
    parameter int unsigned MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
    parameter int unsigned OUT_LANES      = DEF_OUT_LANES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CDATA_W-1:0]  i_cfg_data,
    // coded word input
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [WORD_W-1:0]   i_word,
    input  logic                i_input_end,
    // decoded group output
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [WORD_W-1:0]   o_value_a,
    output logic [WORD_W-1:0]   o_value_b,
    output logic [WORD_W-1:0]   o_value_c,
    output logic [WORD_W-1:0]   o_value_d,
    output logic [LANE_W-1:0]   o_lanes_valid,
    output logic                o_row_done,
    output logic [1:0]          o_status,
    output logic                o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // controller: takes a word when no group is owed, or as the last
    // group of the previous word moves into the output register
    srle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // datapath: all row state is settled at the word's transfer, the
    // emitter then only counts the owed values down a group at a time
    srle_dpath #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .OUT_LANES      (OUT_LANES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_word        (i_word),
        .i_input_end   (i_input_end),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_value_a     (o_value_a),
        .o_value_b     (o_value_b),
        .o_value_c     (o_value_c),
        .o_value_d     (o_value_d),
        .o_lanes_valid (o_lanes_valid),
        .o_row_done    (o_row_done),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule
